@@ rtl/ntc_beta_temperature_macros.svh @@
// ----------------------------------------------------------------------------
// NTC beta temperature assertion macros
// Shared property shorthands, clocked on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef NTC_BETA_TEMPERATURE_MACROS_SVH
`define NTC_BETA_TEMPERATURE_MACROS_SVH

// same-cycle implication
`define NTC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ntc_beta_temperature: property failed");

// next-cycle implication
`define NTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ntc_beta_temperature: property failed");

`endif

@@ rtl/ntc_pkg.sv @@
// ----------------------------------------------------------------------------
// ntc_pkg
// Widths, codes and shared types of the NTC beta temperature pipeline.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int unsigned ADC_BITS = 12;

  // config field widths
  localparam int unsigned RS_W     = 22;
  localparam int unsigned BETA_W   = 15;
  localparam int unsigned MV_W     = 13;
  localparam int unsigned IBIAS_W  = 24;
  localparam int unsigned T0_W     = 16;

  // result field widths
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned R_W      = 24;
  localparam int unsigned ST_W     = 2;

  // datapath widths
  localparam int unsigned VNUM_W   = MV_W + ADC_BITS + 1;
  localparam int unsigned FULL_W   = MV_W + ADC_BITS;
  localparam int unsigned PROD_W   = VNUM_W + RS_W;
  localparam int unsigned NUM_W    = 56;
  localparam int unsigned DEN_W    = 40;
  localparam int unsigned EXP_W    = $clog2(NUM_W);
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned LOG_W    = EXP_W + FRAC_W;
  localparam int unsigned MANT_W   = 31;

  localparam logic [R_W-1:0]    R_MAX         = '1;
  localparam logic [19:0]       UA_PER_NA     = 20'd1000000;
  localparam int unsigned       KELVIN_CENTI  = 27315;
  localparam int unsigned       TEMP_POS_MAX  = 32767;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_ZERO   = 2'd1,
    ST_SUPPLY = 2'd2,
    ST_SAT    = 2'd3
  } status_e;

  // register map, index = paddr / 4
  localparam int unsigned NREG   = 8;
  localparam int unsigned ADDR_W = $clog2(NREG) + 2;

  typedef enum logic [$clog2(NREG)-1:0] {
    REG_MODE   = 3'd0,
    REG_RS     = 3'd1,
    REG_R0     = 3'd2,
    REG_BETA   = 3'd3,
    REG_SUPPLY = 3'd4,
    REG_VREF   = 3'd5,
    REG_IBIAS  = 3'd6,
    REG_T0     = 3'd7
  } reg_e;

  // flags and saturated resistance riding alongside the arithmetic
  typedef struct packed {
    logic           zero;
    logic           supply;
    logic           rsat;
    logic           dnp;
    logic [R_W-1:0] r_out;
  } side_t;

endpackage

@@ rtl/ntc_div.sv @@
// ----------------------------------------------------------------------------
// ntc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ntc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [ntc_pkg::NUM_W-1:0]   num_i,
  input  logic [ntc_pkg::DEN_W-1:0]   den_i,
  input  ntc_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [ntc_pkg::NUM_W-1:0]   quo_o,
  output ntc_pkg::side_t              side_o
);

  localparam int unsigned NW = ntc_pkg::NUM_W;
  localparam int unsigned DW = ntc_pkg::DEN_W;

  logic           v_q    [NW];
  logic [DW-1:0]  rem_q  [NW];
  logic [DW-1:0]  den_q  [NW];
  logic [NW-1:0]  acc_q  [NW];
  ntc_pkg::side_t side_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_bit
    logic           v_in;
    logic [DW-1:0]  rem_in;
    logic [DW-1:0]  den_in;
    logic [NW-1:0]  acc_in;
    ntc_pkg::side_t side_in;
    logic [DW:0]    trial;
    logic           take;

    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign acc_in  = num_i;
      assign side_in = side_i;
    end else begin : g_tail
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign acc_in  = acc_q[k-1];
      assign side_in = side_q[k-1];
    end

    // acc shifts the dividend out at the top and the quotient in at the bottom
    assign trial = {rem_in, acc_in[NW-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        acc_q[k]  <= {acc_in[NW-2:0], take};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = acc_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

@@ rtl/ntc_log2.sv @@
// ----------------------------------------------------------------------------
// ntc_log2
// Two-lane pipelined log2 in Q16: msb search, normalise, 16 squaring steps.
// ----------------------------------------------------------------------------
module ntc_log2 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [ntc_pkg::NUM_W-1:0]   x_i,
  input  logic [ntc_pkg::NUM_W-1:0]   y_i,
  input  ntc_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [ntc_pkg::LOG_W-1:0]   lx_o,
  output logic [ntc_pkg::LOG_W-1:0]   ly_o,
  output ntc_pkg::side_t              side_o
);

  localparam int unsigned NW = ntc_pkg::NUM_W;
  localparam int unsigned EW = ntc_pkg::EXP_W;
  localparam int unsigned FW = ntc_pkg::FRAC_W;
  localparam int unsigned MW = ntc_pkg::MANT_W;

  typedef struct packed {
    logic [EW-1:0] e;
    logic [FW-1:0] frac;
    logic [MW-1:0] m;
  } lane_t;

  function automatic logic [EW-1:0] msb_index(input logic [NW-1:0] x);
    logic [EW-1:0] idx;
    idx = '0;
    for (int i = 0; i < NW; i++) begin
      if (x[i]) begin
        idx = EW'(i);
      end
    end
    return idx;
  endfunction

  // stage A: leading-one position
  logic           a_v_q;
  logic [NW-1:0]  a_x_q [2];
  logic [EW-1:0]  a_e_q [2];
  ntc_pkg::side_t a_side_q;

  // stage B: Q30 mantissa
  logic           b_v_q;
  lane_t          b_ln_q [2];
  ntc_pkg::side_t b_side_q;

  logic [NW+MW-2:0] norm [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      norm[l] = {a_x_q[l], (MW-1)'(0)} >> a_e_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_x_q[0] <= x_i;
      a_x_q[1] <= y_i;
      a_e_q[0] <= msb_index(x_i);
      a_e_q[1] <= msb_index(y_i);
      a_side_q <= side_i;
      for (int l = 0; l < 2; l++) begin
        b_ln_q[l].e    <= a_e_q[l];
        b_ln_q[l].frac <= '0;
        b_ln_q[l].m    <= norm[l][MW-1:0];
      end
      b_side_q <= a_side_q;
    end
  end

  // squaring stages, one fraction bit each
  logic           s_v_q    [FW];
  lane_t          s_ln_q   [FW][2];
  ntc_pkg::side_t s_side_q [FW];

  for (genvar k = 0; k < FW; k++) begin : g_sq
    logic           v_in;
    lane_t          ln_in [2];
    lane_t          ln_d  [2];
    ntc_pkg::side_t side_in;

    if (k == 0) begin : g_head
      assign v_in     = b_v_q;
      assign ln_in[0] = b_ln_q[0];
      assign ln_in[1] = b_ln_q[1];
      assign side_in  = b_side_q;
    end else begin : g_tail
      assign v_in     = s_v_q[k-1];
      assign ln_in[0] = s_ln_q[k-1][0];
      assign ln_in[1] = s_ln_q[k-1][1];
      assign side_in  = s_side_q[k-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [2*MW-1:0] sq;
      logic [MW:0]     s;
      assign sq = (2*MW)'(ln_in[l].m) * (2*MW)'(ln_in[l].m);
      assign s  = sq[2*MW-1:MW-1];
      assign ln_d[l].e    = ln_in[l].e;
      assign ln_d[l].frac = {ln_in[l].frac[FW-2:0], s[MW]};
      assign ln_d[l].m    = s[MW] ? s[MW:1] : s[MW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_v_q[k] <= 1'b0;
      end else if (en_i) begin
        s_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_ln_q[k][0] <= ln_d[0];
        s_ln_q[k][1] <= ln_d[1];
        s_side_q[k]  <= side_in;
      end
    end
  end

  assign valid_o = s_v_q[FW-1];
  assign lx_o    = {s_ln_q[FW-1][0].e, s_ln_q[FW-1][0].frac};
  assign ly_o    = {s_ln_q[FW-1][1].e, s_ln_q[FW-1][1].frac};
  assign side_o  = s_side_q[FW-1];

endmodule

@@ rtl/ntc_beta_temperature.sv @@
// ----------------------------------------------------------------------------
// ntc_beta_temperature
// NTC thermistor temperature by the beta equation, one ADC sample per beat.
// ----------------------------------------------------------------------------
// Takes one ADC beat per clock while not stalled and returns one result beat per
// sample, in order: temperature in 0.01 degC, thermistor resistance in ohms and a status code.
// Fully pipelined: a new sample is accepted every cycle while in_stall_o is low;
// the path runs through the two pipelined restoring dividers (56 stages each),
// the 18-stage log2 unit and the surrounding multiply and add stages. Every
// stage moves on one common enable, which drops only while a finished result
// sits in the output register and out_stall_i is high, so in_stall_o follows
// that condition.
// Config registers over APB at byte address 4*index; write only while the
// pipe is empty. A register other than mode that holds 0 is treated as 1.
// ----------------------------------------------------------------------------
module ntc_beta_temperature (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // sample in
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [11:0]                          adc_sample_i,
  // result out
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ntc_pkg::TEMP_W-1:0]    temperature_centi_c_o,
  output logic [ntc_pkg::R_W-1:0]              resistance_ohm_o,
  output logic [ntc_pkg::ST_W-1:0]             status_o,
  // APB config
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ntc_pkg::ADDR_W-1:0]           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int unsigned AB     = ntc_pkg::ADC_BITS;
  localparam int unsigned VW     = ntc_pkg::VNUM_W;
  localparam int unsigned FLW    = ntc_pkg::FULL_W;
  localparam int unsigned PW     = ntc_pkg::PROD_W;
  localparam int unsigned NW     = ntc_pkg::NUM_W;
  localparam int unsigned DW     = ntc_pkg::DEN_W;
  localparam int unsigned LW     = ntc_pkg::LOG_W;
  localparam int unsigned RW     = ntc_pkg::R_W;
  localparam int unsigned TW     = ntc_pkg::TEMP_W;
  localparam int unsigned DIFF_W = LW + 1;
  localparam int unsigned LN2_W  = 18;
  localparam int unsigned P_W    = DIFF_W + LN2_W;
  localparam int unsigned LNR_W  = P_W - 16;
  localparam int unsigned TL_W   = ntc_pkg::T0_W + 1 + LNR_W;
  localparam int unsigned K_W    = 23;
  localparam int unsigned BT_W   = ntc_pkg::BETA_W + K_W;
  localparam int unsigned NBT_W  = ntc_pkg::BETA_W + ntc_pkg::T0_W;
  localparam int unsigned NUMER_W = NBT_W + K_W;
  localparam int unsigned DEN2_W = TL_W + 1;

  localparam logic signed [LN2_W-1:0] LN2_Q16   = 18'sd45426;
  localparam logic [K_W-1:0]          Q16_CENTI = 23'd6553600;
  localparam logic [NW-1:0]           Q_HI      =
    NW'(ntc_pkg::TEMP_POS_MAX + ntc_pkg::KELVIN_CENTI);

  // --------------------------------------------------------------------------
  // config registers
  // --------------------------------------------------------------------------
  logic                           mode_q;
  logic [ntc_pkg::RS_W-1:0]       rs_q, r0_q;
  logic [ntc_pkg::BETA_W-1:0]     beta_q;
  logic [ntc_pkg::MV_W-1:0]       supply_q, vref_q;
  logic [ntc_pkg::IBIAS_W-1:0]    ibias_q;
  logic [ntc_pkg::T0_W-1:0]       t0_q;
  ntc_pkg::reg_e                  reg_sel;
  logic                           cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = ntc_pkg::reg_e'(paddr[ntc_pkg::ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      rs_q     <= 22'd10000;
      r0_q     <= 22'd10000;
      beta_q   <= 15'd3950;
      supply_q <= 13'd3300;
      vref_q   <= 13'd3300;
      ibias_q  <= 24'd100000;
      t0_q     <= 16'd29815;
    end else if (cfg_wr) begin
      case (reg_sel)
        ntc_pkg::REG_MODE:   mode_q   <= pwdata[0];
        ntc_pkg::REG_RS:     rs_q     <= pwdata[ntc_pkg::RS_W-1:0];
        ntc_pkg::REG_R0:     r0_q     <= pwdata[ntc_pkg::RS_W-1:0];
        ntc_pkg::REG_BETA:   beta_q   <= pwdata[ntc_pkg::BETA_W-1:0];
        ntc_pkg::REG_SUPPLY: supply_q <= pwdata[ntc_pkg::MV_W-1:0];
        ntc_pkg::REG_VREF:   vref_q   <= pwdata[ntc_pkg::MV_W-1:0];
        ntc_pkg::REG_IBIAS:  ibias_q  <= pwdata[ntc_pkg::IBIAS_W-1:0];
        ntc_pkg::REG_T0:     t0_q     <= pwdata[ntc_pkg::T0_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ntc_pkg::REG_MODE:   prdata = 32'(mode_q);
      ntc_pkg::REG_RS:     prdata = 32'(rs_q);
      ntc_pkg::REG_R0:     prdata = 32'(r0_q);
      ntc_pkg::REG_BETA:   prdata = 32'(beta_q);
      ntc_pkg::REG_SUPPLY: prdata = 32'(supply_q);
      ntc_pkg::REG_VREF:   prdata = 32'(vref_q);
      ntc_pkg::REG_IBIAS:  prdata = 32'(ibias_q);
      ntc_pkg::REG_T0:     prdata = 32'(t0_q);
      default:             prdata = '0;
    endcase
  end

  // zero is used as one for everything but mode
  logic [ntc_pkg::RS_W-1:0]    rs_e, r0_e;
  logic [ntc_pkg::BETA_W-1:0]  beta_e;
  logic [ntc_pkg::MV_W-1:0]    supply_e, vref_e;
  logic [ntc_pkg::IBIAS_W-1:0] ibias_e;
  logic [ntc_pkg::T0_W-1:0]    t0_e;

  assign rs_e     = (rs_q     == '0) ? ntc_pkg::RS_W'(1)    : rs_q;
  assign r0_e     = (r0_q     == '0) ? ntc_pkg::RS_W'(1)    : r0_q;
  assign beta_e   = (beta_q   == '0) ? ntc_pkg::BETA_W'(1)  : beta_q;
  assign supply_e = (supply_q == '0) ? ntc_pkg::MV_W'(1)    : supply_q;
  assign vref_e   = (vref_q   == '0) ? ntc_pkg::MV_W'(1)    : vref_q;
  assign ibias_e  = (ibias_q  == '0) ? ntc_pkg::IBIAS_W'(1) : ibias_q;
  assign t0_e     = (t0_q     == '0) ? ntc_pkg::T0_W'(1)    : t0_q;

  // --------------------------------------------------------------------------
  // pipeline enable: everything holds while a result waits on a stall
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // --------------------------------------------------------------------------
  // front end: voltage, resistance numerator and denominator
  // --------------------------------------------------------------------------
  logic           p1_v_q, p2_v_q, p3_v_q, p4_v_q;
  logic [AB-1:0]  p1_smp_q;
  logic [VW-1:0]  p2_vnum_q;
  logic [PW-1:0]  p3_prod_q;
  logic [DW-1:0]  p3_den_q, p4_den_q;
  logic           p3_zero_q, p3_sup_q;
  logic [NW-1:0]  p4_num_q;
  ntc_pkg::side_t p4_side_q;

  logic [VW-1:0]  vprod;
  logic [FLW-1:0] full;
  logic [ntc_pkg::RS_W-1:0] opb;

  assign vprod = VW'(vref_e) * VW'(p1_smp_q);
  assign full  = {supply_e, AB'(0)};
  // current mode multiplies by 10^6 to get ohms from nA
  assign opb   = mode_q ? ntc_pkg::RS_W'(ntc_pkg::UA_PER_NA) : rs_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= in_valid_i;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_smp_q  <= adc_sample_i[AB-1:0];
      p2_vnum_q <= mode_q ? (vprod << 1) : vprod;
      p3_zero_q <= p2_vnum_q == '0;
      p3_sup_q  <= !mode_q && (p2_vnum_q >= VW'(full));
      p3_prod_q <= PW'(p2_vnum_q) * PW'(opb);
      p3_den_q  <= mode_q ? DW'({ibias_e, AB'(0)}) : DW'(VW'(full) - p2_vnum_q);
      // round half up: add half the divisor first
      p4_num_q  <= NW'(p3_prod_q) + NW'(p3_den_q >> 1);
      p4_den_q  <= p3_den_q;
      p4_side_q <= '{zero: p3_zero_q, supply: p3_sup_q, rsat: 1'b0, dnp: 1'b0,
                     r_out: '0};
    end
  end

  logic           d1_v;
  logic [NW-1:0]  d1_quo;
  ntc_pkg::side_t d1_side;

  ntc_div u_div_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p4_v_q),
    .num_i   (p4_num_q),
    .den_i   (p4_den_q),
    .side_i  (p4_side_q),
    .valid_o (d1_v),
    .quo_o   (d1_quo),
    .side_o  (d1_side)
  );

  // --------------------------------------------------------------------------
  // resistance saturation and log2 of R and R0
  // --------------------------------------------------------------------------
  logic           p5_v_q;
  logic [NW-1:0]  p5_x_q;
  ntc_pkg::side_t p5_side_q;
  logic           rsat;

  assign rsat = |d1_quo[NW-1:RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_v_q <= 1'b0;
    end else if (en) begin
      p5_v_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // below one ohm the log still sees one ohm
      p5_x_q    <= (d1_quo == '0) ? NW'(1) : d1_quo;
      p5_side_q <= '{zero: d1_side.zero, supply: d1_side.supply, rsat: rsat,
                     dnp: d1_side.dnp,
                     r_out: rsat ? ntc_pkg::R_MAX : d1_quo[RW-1:0]};
    end
  end

  logic           lg_v;
  logic [LW-1:0]  lg_x, lg_r0;
  ntc_pkg::side_t lg_side;

  ntc_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p5_v_q),
    .x_i     (p5_x_q),
    .y_i     (NW'(r0_e)),
    .side_i  (p5_side_q),
    .valid_o (lg_v),
    .lx_o    (lg_x),
    .ly_o    (lg_r0),
    .side_o  (lg_side)
  );

  // --------------------------------------------------------------------------
  // ln(R/R0) and the beta-equation fraction
  // --------------------------------------------------------------------------
  logic                     p6_v_q, p7_v_q, p8_v_q, p9_v_q, p10_v_q, p11_v_q;
  ntc_pkg::side_t           p6_side_q, p7_side_q, p8_side_q, p9_side_q, p10_side_q;
  ntc_pkg::side_t           p11_side_q;
  logic signed [DIFF_W-1:0] p6_diff_q;
  logic signed [P_W-1:0]    p7_p_q;
  logic signed [LNR_W-1:0]  p8_lnr_q;
  logic signed [TL_W-1:0]   p9_tl_q;
  logic [BT_W-1:0]          p9_bt_q;
  logic [NBT_W-1:0]         p9_nbt_q;
  logic signed [DEN2_W-1:0] p10_den_q;
  logic [NUMER_W-1:0]       p10_numer_q;
  logic [NW-1:0]            p11_num_q;
  logic [DW-1:0]            p11_den_q;

  logic signed [P_W-1:0]    p_rnd;
  logic                     dnp;

  assign p_rnd = p7_p_q + P_W'(32768);
  assign dnp   = p10_den_q[DEN2_W-1] || (p10_den_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p6_v_q  <= 1'b0;
      p7_v_q  <= 1'b0;
      p8_v_q  <= 1'b0;
      p9_v_q  <= 1'b0;
      p10_v_q <= 1'b0;
      p11_v_q <= 1'b0;
    end else if (en) begin
      p6_v_q  <= lg_v;
      p7_v_q  <= p6_v_q;
      p8_v_q  <= p7_v_q;
      p9_v_q  <= p8_v_q;
      p10_v_q <= p9_v_q;
      p11_v_q <= p10_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p6_diff_q   <= $signed({1'b0, lg_x}) - $signed({1'b0, lg_r0});
      p6_side_q   <= lg_side;
      // log2 difference times ln 2, both Q16
      p7_p_q      <= p6_diff_q * LN2_Q16;
      p7_side_q   <= p6_side_q;
      // floor shift of the half-up rounded product
      p8_lnr_q    <= p_rnd[P_W-1:16];
      p8_side_q   <= p7_side_q;
      p9_tl_q     <= $signed({1'b0, t0_e}) * p8_lnr_q;
      p9_bt_q     <= BT_W'(beta_e) * BT_W'(Q16_CENTI);
      p9_nbt_q    <= NBT_W'(beta_e) * NBT_W'(t0_e);
      p9_side_q   <= p8_side_q;
      p10_den_q   <= $signed({1'b0, p9_bt_q}) + DEN2_W'(p9_tl_q);
      p10_numer_q <= NUMER_W'(p9_nbt_q) * NUMER_W'(Q16_CENTI);
      p10_side_q  <= p9_side_q;
      p11_num_q   <= NW'(p10_numer_q) + NW'(p10_den_q[DW-1:1]);
      p11_den_q   <= p10_den_q[DW-1:0];
      p11_side_q  <= '{zero: p10_side_q.zero, supply: p10_side_q.supply,
                       rsat: p10_side_q.rsat, dnp: dnp, r_out: p10_side_q.r_out};
    end
  end

  logic           d2_v;
  logic [NW-1:0]  d2_quo;
  ntc_pkg::side_t d2_side;

  ntc_div u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p11_v_q),
    .num_i   (p11_num_q),
    .den_i   (p11_den_q),
    .side_i  (p11_side_q),
    .valid_o (d2_v),
    .quo_o   (d2_quo),
    .side_o  (d2_side)
  );

  // --------------------------------------------------------------------------
  // output register: kelvin to celsius, clamps and status
  // --------------------------------------------------------------------------
  logic signed [TW-1:0]     temp_d;
  logic [RW-1:0]            res_d;
  ntc_pkg::status_e         st_d;
  logic signed [TW-1:0]     temp_q;
  logic [RW-1:0]            res_q;
  ntc_pkg::status_e         st_q;
  logic [NW-1:0]            tc_full;

  assign tc_full = d2_quo - NW'(ntc_pkg::KELVIN_CENTI);

  always_comb begin
    temp_d = $signed(tc_full[TW-1:0]);
    res_d  = d2_side.r_out;
    st_d   = d2_side.rsat ? ntc_pkg::ST_SAT : ntc_pkg::ST_OK;
    if (d2_side.zero) begin
      temp_d = $signed(TW'(ntc_pkg::TEMP_POS_MAX));
      res_d  = '0;
      st_d   = ntc_pkg::ST_ZERO;
    end else if (d2_side.supply) begin
      temp_d = $signed({1'b1, (TW-1)'(0)});
      res_d  = ntc_pkg::R_MAX;
      st_d   = ntc_pkg::ST_SUPPLY;
    end else if (d2_side.dnp || (d2_quo > Q_HI)) begin
      // quotient is never negative, so only the upper clamp can fire
      temp_d = $signed(TW'(ntc_pkg::TEMP_POS_MAX));
      st_d   = ntc_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      temp_q <= temp_d;
      res_q  <= res_d;
      st_q   <= st_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign temperature_centi_c_o = temp_q;
  assign resistance_ohm_o      = res_q;
  assign status_o              = st_q;

endmodule

@@ rtl/ntc_chk.sv @@
// ----------------------------------------------------------------------------
// ntc_chk
// Port-level checks for ntc_beta_temperature, bound to the top level.
// ----------------------------------------------------------------------------
`include "ntc_beta_temperature_macros.svh"

module ntc_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [ntc_pkg::TEMP_W-1:0] temperature_centi_c_o,
  input logic [ntc_pkg::R_W-1:0]           resistance_ohm_o,
  input logic [ntc_pkg::ST_W-1:0]          status_o
);

  // a held result stays valid, with resistance and status unchanged
  `NTC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(resistance_ohm_o) && $stable(status_o))

  // input side stalls only behind a stuck result
  `NTC_ASSERT_IMPL(a_stall_tie, 1'b1, in_stall_o == (out_valid_o && out_stall_i))

  `NTC_ASSERT_IMPL(a_zero_v, out_valid_o && (status_o == ntc_pkg::ST_ZERO), (temperature_centi_c_o == 16'sh7FFF) && (resistance_ohm_o == '0))

  `NTC_ASSERT_IMPL(a_supply_v, out_valid_o && (status_o == ntc_pkg::ST_SUPPLY), (temperature_centi_c_o == -16'sh8000) && (resistance_ohm_o == ntc_pkg::R_MAX))

endmodule

bind ntc_beta_temperature ntc_chk u_ntc_chk (.*);
